@@ rtl/core/mcmim_pkg.sv @@
// Shared types and constants for the multi-channel minimum interval monitor.
// No dependencies; used by the lane, merge and top-level modules.
`default_nettype none

package mcmim_pkg;

    // Fixed field widths of the result stream and the settle count
    localparam int INTERVAL_W = 16;
    localparam int TS_W       = 48;
    localparam int CHAN_W     = 3;
    localparam int SETTLE_W   = 32;

    // Reset value of a stored minimum
    localparam logic [INTERVAL_W-1:0] MIN_RESET = 16'hFFFF;

    // Input selector carried in tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    // Result event codes carried in tuser
    typedef enum logic [1:0] {
        EV_FIRST  = 2'd0,
        EV_NEWMIN = 2'd1,
        EV_REPORT = 2'd2
    } event_kind_t;

    // Event found by one channel lane for the current item
    typedef struct packed {
        logic                  hit;
        event_kind_t           kind;
        logic [INTERVAL_W-1:0] interval;
    } lane_evt_t;

endpackage : mcmim_pkg

`default_nettype wire

@@ rtl/core/mcmim_lane.sv @@
// One channel lane: toggle tracking, interval measurement and stored minimum.
// Depends on mcmim_pkg.
`default_nettype none

module mcmim_lane #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_go,  // sample after reference
    input  wire logic                                dump_go,
    input  wire logic                                toggle,
    input  wire logic                                settle_ok,  // time above settle count
    input  wire logic [TIME_BITS-1:0]                t_now,
    output mcmim_pkg::lane_evt_t                     evt
);

    logic [TIME_BITS-1:0]                 last_time_reg;
    logic                                 seen_reg;
    logic [mcmim_pkg::INTERVAL_W-1:0]     min_reg;

    logic [TIME_BITS-1:0]                 dt;
    logic                                 better;
    logic                                 measure;
    logic                                 toggled;

    // Interval since the previous toggle and compare against the minimum
    always_comb
    begin
        toggled = sample_go & toggle;
        dt      = t_now - last_time_reg;
        better  = dt < TIME_BITS'(min_reg);
        measure = seen_reg & settle_ok & better;
    end

    // Event for this lane
    always_comb
    begin
        evt.hit = dump_go | (toggled & (~seen_reg | measure));
        if (dump_go)
        begin
            evt.kind     = mcmim_pkg::EV_REPORT;
            evt.interval = min_reg;
        end
        else if (seen_reg)
        begin
            evt.kind     = mcmim_pkg::EV_NEWMIN;
            evt.interval = dt[mcmim_pkg::INTERVAL_W-1:0];
        end
        else
        begin
            evt.kind     = mcmim_pkg::EV_FIRST;
            evt.interval = '0;
        end
    end

    // Toggle time holds no reset value; it is read only once seen_reg is set
    always_ff @(posedge clk)
    begin
        if (toggled)
        begin
            last_time_reg <= t_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            min_reg  <= mcmim_pkg::MIN_RESET;
        end
        else if (toggled)
        begin
            seen_reg <= 1'b1;
            if (measure)
            begin
                min_reg <= dt[mcmim_pkg::INTERVAL_W-1:0];
            end
        end
    end

endmodule : mcmim_lane

`default_nettype wire

@@ rtl/core/mcmim_merge.sv @@
// Merge stage: buffers the lane events of one item and sends them out in
// ascending channel order through an output register. Depends on mcmim_pkg.
`default_nettype none

module mcmim_merge #(
    parameter int CHANNEL_COUNT = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   load,
    input  wire mcmim_pkg::lane_evt_t                   evt [CHANNEL_COUNT],
    input  wire logic [mcmim_pkg::TS_W-1:0]             ts_in,
    output logic                                        buf_ready,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output mcmim_pkg::event_kind_t                      out_kind,
    output logic [mcmim_pkg::CHAN_W-1:0]                out_channel,
    output logic [mcmim_pkg::INTERVAL_W-1:0]            out_interval,
    output logic [mcmim_pkg::TS_W-1:0]                  out_ts,
    output logic                                        out_last
);

    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [CHANNEL_COUNT-1:0]               pend_reg;
    logic [CHANNEL_COUNT-1:0]               pend_next;
    mcmim_pkg::event_kind_t                 kind_reg [CHANNEL_COUNT];
    logic [mcmim_pkg::INTERVAL_W-1:0]       ival_reg [CHANNEL_COUNT];
    logic [mcmim_pkg::TS_W-1:0]             ts_reg;

    logic                                   out_valid_reg;
    mcmim_pkg::event_kind_t                 out_kind_reg;
    logic [mcmim_pkg::CHAN_W-1:0]           out_channel_reg;
    logic [mcmim_pkg::INTERVAL_W-1:0]       out_interval_reg;
    logic [mcmim_pkg::TS_W-1:0]             out_ts_reg;
    logic                                   out_last_reg;

    logic [CHANNEL_COUNT-1:0]               sel;
    logic [CHANNEL_COUNT-1:0]               rest;
    logic [IDX_W-1:0]                       sel_idx;
    logic [1:0]                             sel_kind_bits;
    logic [mcmim_pkg::INTERVAL_W-1:0]       sel_ival;
    logic                                   sel_last;
    logic                                   out_free;
    logic                                   move;

    // Lowest pending lane and its fields
    always_comb
    begin
        sel           = pend_reg & (~pend_reg + CHANNEL_COUNT'(1));
        rest          = pend_reg & ~sel;
        sel_last      = (rest == '0);
        sel_idx       = '0;
        sel_kind_bits = '0;
        sel_ival      = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            if (sel[i])
            begin
                sel_idx = IDX_W'(i);
            end
            sel_kind_bits = sel_kind_bits | ({2{sel[i]}} & kind_reg[i]);
            sel_ival      = sel_ival | ({mcmim_pkg::INTERVAL_W{sel[i]}} & ival_reg[i]);
        end
    end

    // Handshake between buffer, output register and input side
    always_comb
    begin
        out_free  = ~out_valid_reg | out_ready;
        move      = (pend_reg != '0) & out_free;
        buf_ready = sel_last & ((pend_reg == '0) | out_free);
        if (load)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                pend_next[i] = evt[i].hit;
            end
        end
        else if (move)
        begin
            pend_next = rest;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    // Event buffer payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ts_reg <= ts_in;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                kind_reg[i] <= evt[i].kind;
                ival_reg[i] <= evt[i].interval;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_kind_reg     <= mcmim_pkg::event_kind_t'(sel_kind_bits);
            out_channel_reg  <= mcmim_pkg::CHAN_W'(sel_idx);
            out_interval_reg <= sel_ival;
            out_ts_reg       <= ts_reg;
            out_last_reg     <= sel_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_channel  = out_channel_reg;
    assign out_interval = out_interval_reg;
    assign out_ts       = out_ts_reg;
    assign out_last     = out_last_reg;

`ifndef SYNTHESIS
    // A new item only lands once at most one event of the previous one is left
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> $countones(pend_reg) <= 1)
        else $error("merge: item loaded over pending events");

    // The final event of an item carries the last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (move && $onehot(pend_reg)) |=> out_last_reg)
        else $error("merge: final event without last flag");

    // An event that is not final never carries the last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (move && $countones(pend_reg) > 1) |=> (out_valid_reg && !out_last_reg))
        else $error("merge: last flag on inner event");
`endif

endmodule : mcmim_merge

`default_nettype wire

@@ rtl/core/multi_channel_min_interval_monitor_top.sv @@
// Top level of the multi-channel minimum interval monitor: reference and
// timestamp control, channel lanes and merge stage. Depends on mcmim_pkg,
// mcmim_lane and mcmim_merge.
//
//  Channel   Direction  Signals                     Contents
//  s_axis    in         tvalid tready tuser tdata   tuser: kind; tdata: sample_word
//  m_axis    out        tvalid tready tuser tlast   tuser: event_kind; tlast: last;
//                       tdata                       tdata: channel, interval, timestamp
//  cfg       in         cfg_we cfg_wdata            settle_samples
//
//  An item is evaluated by all lanes in the cycle it is transferred; its results
//  leave the merge buffer at one result per cycle while m_axis is not stalled, so
//  sample words with at most one toggle stream at one per clock while m_axis is
//  not stalled. A dump yields one result for every channel.
//  rst_n clears the reference flag, timestamp, seen flags and minima (0xFFFF).
//  A stalled m_axis holds the output register; s_axis is taken again once the
//  buffer is down to the result moving out.
`default_nettype none

module multi_channel_min_interval_monitor_top #(
    parameter int CHANNEL_COUNT = 8,
    parameter int TIME_BITS     = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,      // settle_samples
    // input stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic          s_axis_tuser,   // kind
    input  wire logic [15:0]   s_axis_tdata,   // sample_word
    // result stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [1:0]         m_axis_tuser,   // event_kind
    output logic               m_axis_tlast,   // last
    output logic [71:0]        m_axis_tdata    // channel[2:0], interval[18:3], timestamp[66:19]
);

    localparam int CMP_W = (TIME_BITS > mcmim_pkg::SETTLE_W) ? TIME_BITS
                                                             : mcmim_pkg::SETTLE_W;

    logic [mcmim_pkg::SETTLE_W-1:0]     settle_reg;
    logic                               ref_taken_reg;
    logic [CHANNEL_COUNT-1:0]           prev_levels_reg;
    logic [TIME_BITS-1:0]               sample_time_reg;

    logic                               accept;
    logic                               is_dump;
    logic                               sample_go;
    logic                               dump_go;
    logic                               ref_load;
    logic [CHANNEL_COUNT-1:0]           levels;
    logic [CHANNEL_COUNT-1:0]           toggles;
    logic [TIME_BITS-1:0]               t_inc;
    logic [TIME_BITS-1:0]               t_item;
    logic [TIME_BITS+mcmim_pkg::TS_W-1:0] t_wide;
    logic                               settle_ok;

    mcmim_pkg::lane_evt_t               evt [CHANNEL_COUNT];
    mcmim_pkg::event_kind_t             out_kind;
    logic [mcmim_pkg::CHAN_W-1:0]       out_channel;
    logic [mcmim_pkg::INTERVAL_W-1:0]   out_interval;
    logic [mcmim_pkg::TS_W-1:0]         out_ts;
    logic                               buf_ready;

    // Input decode and timestamp
    always_comb
    begin
        accept    = s_axis_tvalid & s_axis_tready;
        is_dump   = (s_axis_tuser == mcmim_pkg::KIND_DUMP);
        dump_go   = accept & is_dump;
        ref_load  = accept & ~is_dump & ~ref_taken_reg;
        sample_go = accept & ~is_dump & ref_taken_reg;
        levels    = s_axis_tdata[CHANNEL_COUNT-1:0];
        toggles   = prev_levels_reg ^ levels;
        t_inc     = (sample_time_reg == '1) ? sample_time_reg
                                            : sample_time_reg + TIME_BITS'(1);
        t_item    = is_dump ? sample_time_reg : t_inc;
        t_wide    = {{mcmim_pkg::TS_W{1'b0}}, t_item};
        settle_ok = CMP_W'(t_inc) > CMP_W'(settle_reg);
    end

    // Settle count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= '0;
        end
        else if (cfg_we)
        begin
            settle_reg <= cfg_wdata;
        end
    end

    // Reference levels and saturating sample time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_taken_reg   <= 1'b0;
            prev_levels_reg <= '0;
            sample_time_reg <= '0;
        end
        else if (ref_load)
        begin
            ref_taken_reg   <= 1'b1;
            prev_levels_reg <= levels;
            sample_time_reg <= '0;
        end
        else if (sample_go)
        begin
            prev_levels_reg <= levels;
            sample_time_reg <= t_inc;
        end
    end

    // Channel lanes
    for (genvar g = 0; g < CHANNEL_COUNT; g++)
    begin : g_lane
        mcmim_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .sample_go (sample_go),
            .dump_go   (dump_go),
            .toggle    (toggles[g]),
            .settle_ok (settle_ok),
            .t_now     (t_inc),
            .evt       (evt[g])
        );
    end

    // Merge and output register
    mcmim_merge #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .evt          (evt),
        .ts_in        (t_wide[mcmim_pkg::TS_W-1:0]),
        .buf_ready    (buf_ready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_kind     (out_kind),
        .out_channel  (out_channel),
        .out_interval (out_interval),
        .out_ts       (out_ts),
        .out_last     (m_axis_tlast)
    );

    assign s_axis_tready = buf_ready;
    assign m_axis_tuser  = out_kind;
    assign m_axis_tdata  = {5'b0, out_ts, out_interval, out_channel};

`ifndef SYNTHESIS
    // The first sample word sets the reference at time zero
    assert property (@(posedge clk) disable iff (!rst_n)
        ref_load |=> (ref_taken_reg && sample_time_reg == '0))
        else $error("top: reference sample not taken");

    // Sample time never runs backwards once the reference is set
    assert property (@(posedge clk) disable iff (!rst_n)
        (ref_taken_reg && $past(ref_taken_reg)) |-> sample_time_reg >= $past(sample_time_reg))
        else $error("top: sample time decreased");

    // Time stays at zero until the reference sample arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        !ref_taken_reg |-> sample_time_reg == '0)
        else $error("top: sample time moved before reference");
`endif

endmodule : multi_channel_min_interval_monitor_top

`default_nettype wire
